// File: rtl/sbt_pkg.sv
// Shared types, constants and helper functions of the sprite bounce transform.
package sbt_pkg;

  localparam int IDX_W  = 18;
  localparam int POS_W  = 20;
  localparam int VEL_W  = 14;
  localparam int ANG_W  = 16;
  localparam int RATE_W = 13;
  localparam int TRIG_W = 16;
  localparam int NDC_W  = 16;

  localparam int SCREEN_WIDTH  = 1600;
  localparam int SCREEN_HEIGHT = 900;

  localparam int TWO_PI_Q13  = 51472;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int TWO_PI_Q16  = 411775;

  localparam int CORDIC_X0    = 65203287;
  localparam int CORDIC_STEPS = 16;
  localparam int XY_W         = 30;
  localparam int Z_W          = 20;

  // The NDC term is a floor division by twice the screen size, done as a
  // multiplication by a reciprocal that is exact over the unsaturated range.
  localparam int DIV_X    = 2 * SCREEN_WIDTH;
  localparam int DIV_Y    = 2 * SCREEN_HEIGHT;
  localparam int DIV_L    = $clog2(DIV_X > DIV_Y ? DIV_X : DIV_Y);
  localparam int NUM_W    = POS_W + 9;
  localparam int NP_W     = NDC_W + DIV_L;
  localparam int RECIP_S  = NDC_W + 2 * DIV_L;
  localparam int RECIP_W  = NDC_W + DIV_L + 2;
  localparam int PROD_W   = NP_W + RECIP_W;
  localparam longint RECIP_X = ((longint'(1) <<< RECIP_S) + DIV_X - 1) / DIV_X;
  localparam longint RECIP_Y = ((longint'(1) <<< RECIP_S) + DIV_Y - 1) / DIV_Y;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [ANG_W-1:0]        angle;
  } sprite_t;

  typedef struct packed {
    logic [NP_W-1:0] np;
    logic            under;
    logic            over;
  } ndc_arg_t;

  typedef struct packed {
    sprite_t               spr;
    logic signed [Z_W-1:0] z;
    logic                  neg;
    ndc_arg_t              ndx;
    ndc_arg_t              ndy;
  } front_item_t;

  typedef struct packed {
    sprite_t                spr;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   neg;
    ndc_arg_t               ndx;
    ndc_arg_t               ndy;
    logic [NDC_W-1:0]       ndc_x;
    logic [NDC_W-1:0]       ndc_y;
  } cordic_t;

  typedef struct packed {
    sprite_t                  spr;
    logic signed [TRIG_W-1:0] cos_t;
    logic signed [TRIG_W-1:0] sin_t;
    logic [NDC_W-1:0]         ndc_x;
    logic [NDC_W-1:0]         ndc_y;
  } result_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      0:       r = Z_W'(51472);
      1:       r = Z_W'(30386);
      2:       r = Z_W'(16055);
      3:       r = Z_W'(8150);
      4:       r = Z_W'(4091);
      5:       r = Z_W'(2047);
      6:       r = Z_W'(1024);
      7:       r = Z_W'(512);
      8:       r = Z_W'(256);
      9:       r = Z_W'(128);
      10:      r = Z_W'(64);
      11:      r = Z_W'(32);
      12:      r = Z_W'(16);
      13:      r = Z_W'(8);
      14:      r = Z_W'(4);
      15:      r = Z_W'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Offsets the numerator so no unsaturated quotient is negative; the flags mark
  // quotients that saturate either way.
  function automatic ndc_arg_t ndc_prep(input logic signed [POS_W-1:0] p, input int size);
    logic signed [NUM_W:0] n;
    ndc_arg_t r;
    n = {{(NUM_W + 1 - POS_W){p[POS_W-1]}}, p};
    n = (n <<< 8) + (NUM_W + 1)'(size) + (NUM_W + 1)'(longint'(16384) * 2 * size);
    r.under = n[NUM_W];
    r.over  = !n[NUM_W] && (n >= (NUM_W + 1)'(longint'(65536) * 2 * size));
    r.np    = n[NP_W-1:0];
    return r;
  endfunction

  // The offset quotient minus 32768 is the quotient with its top bit flipped.
  function automatic logic [NDC_W-1:0] ndc_finish(input logic [PROD_W-1:0] prod,
                                                  input logic under, input logic over);
    logic [NDC_W-1:0] q;
    q = prod[RECIP_S +: NDC_W];
    if (under) begin
      return {1'b1, {(NDC_W - 1){1'b0}}};
    end else if (over) begin
      return {1'b0, {(NDC_W - 1){1'b1}}};
    end
    return {~q[NDC_W-1], q[NDC_W-2:0]};
  endfunction

endpackage

// File: rtl/sbt_front.sv
// Front end: position bounce, angle wrap, quadrant fold and NDC operand setup.
module sbt_front import sbt_pkg::*; (
  input  logic [IDX_W-1:0]        sprite_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [VEL_W-1:0] vel_x,
  input  logic signed [VEL_W-1:0] vel_y,
  input  logic [ANG_W-1:0]        angle,
  input  logic [RATE_W-1:0]       angle_rate,
  output front_item_t             item
);

  localparam logic signed [POS_W:0] POS_MAX = (POS_W + 1)'(2 ** (POS_W - 1) - 1);
  localparam logic signed [POS_W:0] POS_MIN = -(POS_W + 1)'(2 ** (POS_W - 1));
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W - 1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W - 1){1'b1}}};

  function automatic logic signed [POS_W-1:0] step_pos(input logic signed [POS_W-1:0] p,
                                                       input logic signed [VEL_W-1:0] v);
    logic signed [POS_W:0] s;
    s = {p[POS_W-1], p} + {{(POS_W + 1 - VEL_W){v[VEL_W-1]}}, v};
    if (s > POS_MAX) begin
      return POS_MAX[POS_W-1:0];
    end else if (s < POS_MIN) begin
      return POS_MIN[POS_W-1:0];
    end
    return s[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] bounce(input logic signed [POS_W-1:0] q,
                                                     input logic signed [VEL_W-1:0] v,
                                                     input int size);
    logic outside;
    outside = q[POS_W-1] || ($signed({q[POS_W-1], q}) > (POS_W + 1)'(size * 256));
    if (!outside) begin
      return v;
    end else if (v == VEL_MIN) begin
      return VEL_MAX;
    end
    return -v;
  endfunction

  logic signed [POS_W-1:0] npx, npy;
  logic [ANG_W:0]          asum, awrap;
  logic signed [Z_W-1:0]   z0, z1, z2;
  logic                    neg;

  always_comb begin
    npx = step_pos(pos_x, vel_x);
    npy = step_pos(pos_y, vel_y);

    asum  = {1'b0, angle} + (ANG_W + 1)'(angle_rate);
    awrap = (asum > (ANG_W + 1)'(TWO_PI_Q13)) ? asum - (ANG_W + 1)'(TWO_PI_Q13) : asum;

    // Fold into the half-plane that CORDIC converges on; both outputs flip sign.
    z0  = Z_W'({awrap, 3'b000});
    z1  = (z0 > Z_W'(PI_Q16)) ? z0 - Z_W'(TWO_PI_Q16) : z0;
    neg = 1'b0;
    z2  = z1;
    if (z1 > Z_W'(HALF_PI_Q16)) begin
      z2  = z1 - Z_W'(PI_Q16);
      neg = 1'b1;
    end else if (z1 < -Z_W'(HALF_PI_Q16)) begin
      z2  = z1 + Z_W'(PI_Q16);
      neg = 1'b1;
    end

    item.spr.index = sprite_index;
    item.spr.pos_x = npx;
    item.spr.pos_y = npy;
    item.spr.vel_x = bounce(npx, vel_x, SCREEN_WIDTH);
    item.spr.vel_y = bounce(npy, vel_y, SCREEN_HEIGHT);
    item.spr.angle = awrap[ANG_W-1:0];
    item.z         = z2;
    item.neg       = neg;
    item.ndx       = ndc_prep(npx, SCREEN_WIDTH);
    item.ndy       = ndc_prep(npy, SCREEN_HEIGHT);
  end

endmodule

// File: rtl/sbt_queue.sv
// Short queue that decouples the front end from the trig pipeline.
module sbt_queue import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t wdata,
  output logic        full,
  input  logic        pop,
  output front_item_t rdata,
  output logic        empty
);

  front_item_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] cnt;
  logic              do_push, do_pop;

  assign full    = (cnt == QCNT_W'(QDEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// File: rtl/sbt_back.sv
// Back end: pipelined CORDIC, NDC reciprocal multiply and the result buffer.
module sbt_back import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  front_item_t q_data,
  output logic        q_pop,
  output result_t     rdata,
  output logic        empty,
  input  logic        pop
);

  localparam int LAST = CORDIC_STEPS;

  function automatic cordic_t cordic_step(input cordic_t a, input int i);
    cordic_t r;
    logic signed [XY_W-1:0] dx, dy;
    r  = a;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (!a.z[Z_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_q16(i);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_q16(i);
    end
    return r;
  endfunction

  cordic_t            st [CORDIC_STEPS+1];
  logic [LAST:0]      pv;
  logic               en;
  logic [PROD_W-1:0]  prod_x, prod_y;
  cordic_t            load;

  result_t            oq [2];
  logic               owp, orp;
  logic [1:0]         ocnt;
  logic               oq_full, oq_push, oq_pop;
  result_t            res;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [TRIG_W-1:0] xr, yr;

  // The whole pipe holds only while a finished item cannot enter the buffer.
  assign oq_full = (ocnt == 2'd2);
  assign en      = !(pv[LAST] && oq_full);
  assign q_pop   = en && !q_empty;

  always_comb begin
    load.spr   = q_data.spr;
    load.x     = XY_W'(CORDIC_X0);
    load.y     = '0;
    load.z     = q_data.z;
    load.neg   = q_data.neg;
    load.ndx   = q_data.ndx;
    load.ndy   = q_data.ndy;
    load.ndc_x = '0;
    load.ndc_y = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[LAST-1:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]  <= load;
      prod_x <= PROD_W'(st[0].ndx.np) * PROD_W'(RECIP_X);
      prod_y <= PROD_W'(st[0].ndy.np) * PROD_W'(RECIP_Y);
    end
  end

  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_stage
    cordic_t nx;
    always_comb begin
      nx = cordic_step(st[k-1], k - 1);
      // The products line up with stage one; the NDC terms settle here.
      if (k == 2) begin
        nx.ndc_x = ndc_finish(prod_x, st[1].ndx.under, st[1].ndx.over);
        nx.ndc_y = ndc_finish(prod_y, st[1].ndy.under, st[1].ndy.over);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nx;
      end
    end
  end

  // Rounded results are at most 15 bits, so the negation cannot overflow.
  always_comb begin
    xs        = st[LAST].x + XY_W'(16384);
    ys        = st[LAST].y + XY_W'(16384);
    xr        = TRIG_W'($signed(xs[XY_W-1:15]));
    yr        = TRIG_W'($signed(ys[XY_W-1:15]));
    res.spr   = st[LAST].spr;
    res.cos_t = st[LAST].neg ? -xr : xr;
    res.sin_t = st[LAST].neg ? -yr : yr;
    res.ndc_x = st[LAST].ndc_x;
    res.ndc_y = st[LAST].ndc_y;
  end

  assign oq_push = en && pv[LAST];
  assign empty   = (ocnt == 2'd0);
  assign oq_pop  = pop && !empty;
  assign rdata   = oq[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (oq_push) begin
        owp <= ~owp;
      end
      if (oq_pop) begin
        orp <= ~orp;
      end
      ocnt <= ocnt + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[owp] <= res;
    end
  end

  a_ocnt: assert property (@(posedge clk) disable iff (rst) ocnt <= 2'd2)
    else $error("result buffer count out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    pv[LAST] && oq_full |=> pv[LAST] && $stable(st[LAST]))
    else $error("stalled pipeline lost its last item");

  a_keep: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished without a transfer");

endmodule

// File: rtl/sprite_bounce_transform.sv
// Top level of the sprite bounce transform: front end, queue and trig pipeline.
//
// Each sprite is one transfer in and one transfer out, in order, and the block
// sustains one sprite per clock cycle while results are popped and the result
// buffer has room. A sprite is taken into a four-entry queue in the cycle it is
// pushed. It then passes a load stage, the sixteen-stage CORDIC pipeline,
// one iteration per stage, and a two-entry result buffer. The NDC division
// by the screen size runs as a reciprocal multiply alongside the first stages.
module sprite_bounce_transform import sbt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [IDX_W-1:0]         sprite_index,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [VEL_W-1:0]  vel_x,
  input  logic signed [VEL_W-1:0]  vel_y,
  input  logic [ANG_W-1:0]         angle,
  input  logic [RATE_W-1:0]        angle_rate,
  output logic                     empty,
  input  logic                     pop,
  output logic [IDX_W-1:0]         index_out,
  output logic signed [POS_W-1:0]  new_pos_x,
  output logic signed [POS_W-1:0]  new_pos_y,
  output logic signed [VEL_W-1:0]  new_vel_x,
  output logic signed [VEL_W-1:0]  new_vel_y,
  output logic [ANG_W-1:0]         new_angle,
  output logic signed [TRIG_W-1:0] scaled_cos,
  output logic signed [TRIG_W-1:0] scaled_sin,
  output logic signed [NDC_W-1:0]  ndc_x,
  output logic signed [NDC_W-1:0]  ndc_y
);

  front_item_t item, q_data;
  logic        q_empty, q_pop;
  result_t     res;

  sbt_front u_front (
    .sprite_index (sprite_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .angle        (angle),
    .angle_rate   (angle_rate),
    .item         (item)
  );

  sbt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  sbt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .rdata   (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign index_out  = res.spr.index;
  assign new_pos_x  = res.spr.pos_x;
  assign new_pos_y  = res.spr.pos_y;
  assign new_vel_x  = res.spr.vel_x;
  assign new_vel_y  = res.spr.vel_y;
  assign new_angle  = res.spr.angle;
  assign scaled_cos = res.cos_t;
  assign scaled_sin = res.sin_t;
  assign ndc_x      = res.ndc_x;
  assign ndc_y      = res.ndc_y;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the sprite bounce transform.
`timescale 1ns / 1ps

module testbench;
  import sbt_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic [ANG_W-1:0]         ang;
    logic [RATE_W-1:0]        rate;
  } sprite_in_t;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic [ANG_W-1:0]         ang;
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
    logic signed [NDC_W-1:0]  nx;
    logic signed [NDC_W-1:0]  ny;
  } sprite_out_t;

  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  logic [IDX_W-1:0]         sprite_index = '0;
  logic signed [POS_W-1:0]  pos_x = '0, pos_y = '0;
  logic signed [VEL_W-1:0]  vel_x = '0, vel_y = '0;
  logic [ANG_W-1:0]         angle = '0;
  logic [RATE_W-1:0]        angle_rate = '0;
  logic [IDX_W-1:0]         index_out;
  logic signed [POS_W-1:0]  new_pos_x, new_pos_y;
  logic signed [VEL_W-1:0]  new_vel_x, new_vel_y;
  logic [ANG_W-1:0]         new_angle;
  logic signed [TRIG_W-1:0] scaled_cos, scaled_sin;
  logic signed [NDC_W-1:0]  ndc_x, ndc_y;

  sprite_bounce_transform dut (.*);

  sprite_in_t  pending_sprites[$];
  sprite_out_t expected_updates[$];
  int  errors = 0;
  int  checked = 0;
  int  sent = 0;
  bit  stim_done = 0;
  bit  hold_sender = 0;
  bit  calm = 0;
  bit  took_last = 0;
  longint cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint ndc_of(longint p, longint size);
    longint num, q;
    num = p * 256 + size;
    if (num >= 0) q = num / (2 * size);
    else q = -((-num + 2 * size - 1) / (2 * size));
    return clamp(q - 16384, -32768, 32767);
  endfunction

  function automatic void bounce_axis(longint p, longint v, longint size,
                                      output longint np, output longint nv);
    np = clamp(p + v, -524288, 524287);
    nv = (np > size * 256 || np < 0) ? clamp(-v, -8192, 8191) : v;
  endfunction

  function automatic sprite_out_t predict_update(sprite_in_t s);
    sprite_out_t r;
    longint np, nv, a, z, x, y, dx, dy;
    longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    bit flip;
    r.index = s.index;
    bounce_axis(longint'(s.px), longint'(s.vx), longint'(SCREEN_WIDTH), np, nv);
    r.px = POS_W'(np); r.vx = VEL_W'(nv);
    r.nx = NDC_W'(ndc_of(np, longint'(SCREEN_WIDTH)));
    bounce_axis(longint'(s.py), longint'(s.vy), longint'(SCREEN_HEIGHT), np, nv);
    r.py = POS_W'(np); r.vy = VEL_W'(nv);
    r.ny = NDC_W'(ndc_of(np, longint'(SCREEN_HEIGHT)));
    a = longint'(s.ang) + longint'(s.rate);
    if (a > TWO_PI_Q13) a -= TWO_PI_Q13;
    r.ang = ANG_W'(a);
    z = a * 8;
    flip = 0;
    while (z > PI_Q16) z -= TWO_PI_Q16;
    if (z > HALF_PI_Q16) begin
      z -= PI_Q16; flip = 1;
    end else if (z < -HALF_PI_Q16) begin
      z += PI_Q16; flip = 1;
    end
    x = longint'(CORDIC_X0); y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = fshr(x + 16384, 15);
    y = fshr(y + 16384, 15);
    if (flip) begin
      x = -x; y = -y;
    end
    r.cs = TRIG_W'(clamp(x, -32768, 32767));
    r.sn = TRIG_W'(clamp(y, -32768, 32767));
    return r;
  endfunction

  function automatic sprite_in_t random_sprite();
    sprite_in_t s;
    int lim, off;
    s.index = IDX_W'($urandom);
    s.rate = RATE_W'($urandom);
    s.ang = ($urandom_range(0, 3) == 0) ? ANG_W'($urandom) : ANG_W'($urandom_range(0, 51472));
    s.vx = VEL_W'($urandom);
    s.vy = VEL_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        s.px = POS_W'($urandom); s.py = POS_W'($urandom);
      end
      1: begin
        s.px = POS_W'(int'($urandom_range(0, 1600 * 256 + 8192)) - 4096);
        s.py = POS_W'(int'($urandom_range(0, 900 * 256 + 8192)) - 4096);
      end
      2: begin
        lim = ($urandom_range(0, 1) != 0) ? 524287 : -524288;
        off = int'($urandom_range(0, 9000)) - 4500;
        s.px = POS_W'(lim + off);
        lim = ($urandom_range(0, 1) != 0) ? 900 * 256 : 0;
        s.py = POS_W'(lim + int'($urandom_range(0, 600)) - 300);
      end
      default: begin
        lim = ($urandom_range(0, 1) != 0) ? 1600 * 256 : 0;
        s.px = POS_W'(lim + int'($urandom_range(0, 600)) - 300);
        lim = ($urandom_range(0, 1) != 0) ? 524287 : -524288;
        s.py = POS_W'(lim + int'($urandom_range(0, 600)) - 300);
      end
    endcase
    return s;
  endfunction

  function automatic sprite_in_t mk(int idx, int px, int py, int vx, int vy, int ang, int rate);
    sprite_in_t s;
    s.index = IDX_W'(idx); s.px = POS_W'(px); s.py = POS_W'(py);
    s.vx = VEL_W'(vx); s.vy = VEL_W'(vy); s.ang = ANG_W'(ang); s.rate = RATE_W'(rate);
    return s;
  endfunction

  // Driver: a new transfer is offered at the falling edge once the last one went.
  always @(negedge clk) begin
    if (!rst) begin
      if (!push || took_last) begin
        if (pending_sprites.size() > 0 && !hold_sender &&
            (calm || $urandom_range(0, 99) >= 22)) begin
          sprite_in_t s;
          s = pending_sprites.pop_front();
          sprite_index <= s.index; pos_x <= s.px; pos_y <= s.py;
          vel_x <= s.vx; vel_y <= s.vy; angle <= s.ang; angle_rate <= s.rate;
          push <= 1;
        end else begin
          push <= 0;
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  // Monitor: transfers are observed at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    took_last <= !rst && push && !full;
    if (!rst) begin
      if (push && !full) begin
        sprite_in_t s;
        s.index = sprite_index; s.px = pos_x; s.py = pos_y;
        s.vx = vel_x; s.vy = vel_y; s.ang = angle; s.rate = angle_rate;
        expected_updates.push_back(predict_update(s));
        sent <= sent + 1;
      end
      if (pop && !empty) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: result with no sprite pending, index %0d", $time, index_out);
          errors <= errors + 1;
        end else begin
          sprite_out_t e;
          e = expected_updates.pop_front();
          checked <= checked + 1;
          if (e.index !== index_out || e.px !== new_pos_x || e.py !== new_pos_y ||
              e.vx !== new_vel_x || e.vy !== new_vel_y || e.ang !== new_angle ||
              e.cs !== scaled_cos || e.sn !== scaled_sin || e.nx !== ndc_x ||
              e.ny !== ndc_y) begin
            $display("%0t: mismatch idx %0d exp pos %0d,%0d vel %0d,%0d ang %0d",
                     $time, e.index, e.px, e.py, e.vx, e.vy, e.ang);
            $display("   exp cos %0d sin %0d ndc %0d,%0d", e.cs, e.sn, e.nx, e.ny);
            $display("   got idx %0d pos %0d,%0d vel %0d,%0d ang %0d cos %0d sin %0d ndc %0d,%0d",
                     index_out, new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_angle,
                     scaled_cos, scaled_sin, ndc_x, ndc_y);
            errors <= errors + 1;
          end
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_updates.size());
      $display("[sprite_bounce_transform] ERROR");
      $finish;
    end
  end

  initial begin
    // Directed corners: field extremes, saturation, bounce edges, angle wrap.
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    pending_sprites.push_back(mk(262143, 524287, 524287, 8191, 8191, 65535, 8191));
    pending_sprites.push_back(mk(262143, -524288, -524288, -8192, -8192, 65535, 8191));
    pending_sprites.push_back(mk(5, 100, 100, -8192, -8192, 51472, 0));
    pending_sprites.push_back(mk(6, 409600, 230400, 0, 0, 51471, 1));
    pending_sprites.push_back(mk(7, 409600, 230400, 1, 1, 51472, 1));
    pending_sprites.push_back(mk(8, 0, 0, -1, -1, 12868, 0));
    pending_sprites.push_back(mk(9, 1, 1, -1, -1, 25736, 0));
    pending_sprites.push_back(mk(10, 524000, -524000, 8191, -8192, 38604, 4000));
    pending_sprites.push_back(mk(11, 409599, 230399, 1, 1, 25735, 8191));
    pending_sprites.push_back(mk(12, 204800, 115200, 100, -100, 60000, 5000));
    pending_sprites.push_back(mk(13, -200, 300000, 8191, -5000, 6434, 6434));
    pending_sprites.push_back(mk(14, 1000, 1000, 8191, 8191, 43000, 8191));
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 0;
    for (int i = 0; i < 1150; i++) begin
      if (i == 300) begin
        wait (pending_sprites.size() == 0);
        hold_sender = 1;
        wait (!push && expected_updates.size() == 0);
        hold_sender = 0;
      end
      calm = (i >= 600 && i < 800);
      pending_sprites.push_back(random_sprite());
      if (pending_sprites.size() > 8) wait (pending_sprites.size() <= 8);
    end
    wait (pending_sprites.size() == 0 && !push);
    calm = 0;
    wait (expected_updates.size() == 0);
    repeat (LATENCY) @(posedge clk);
    $display("Sent %0d sprites and checked %0d updates, covering bounces, saturation,",
             sent, checked);
    $display("angle wrap and all quadrants under random stalls on both sides.");
    if (errors == 0 && expected_updates.size() == 0) begin
      $display("[sprite_bounce_transform] OK");
    end else begin
      $display("[sprite_bounce_transform] ERROR");
    end
    $finish;
  end

endmodule
